// ----- src/scma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scma_pkg
// Shared widths, constants and sequencer states of the six channel moving
// average filter.
// ----------------------------------------------------------------------------
package scma_pkg;

    // channel and window geometry
    localparam int CHANNELS       = 6;
    localparam int MAX_WINDOW     = 256;
    localparam int SAMPLE_W       = 16;
    localparam int WIN_W          = 9;
    localparam int SLOT_W         = $clog2(MAX_WINDOW);
    localparam int CH_W           = $clog2(CHANNELS);
    localparam int ROW_W          = CHANNELS * SAMPLE_W;

    // running sum: 16-bit samples over up to MAX_WINDOW slots, plus sign
    localparam int SUM_W          = SAMPLE_W + SLOT_W + 1;
    localparam int EXT_W          = SUM_W - SAMPLE_W;
    localparam int QUO_W          = SUM_W - 1;
    localparam int CNT_W          = $clog2(QUO_W + 1);

    localparam logic [WIN_W-1:0]  DEFAULT_WINDOW = WIN_W'(5);
    localparam logic [WIN_W-1:0]  WINDOW_LIMIT   = WIN_W'(MAX_WINDOW);
    localparam logic [CH_W-1:0]   LAST_CH        = CH_W'(CHANNELS - 1);
    localparam logic [CNT_W-1:0]  DIV_STEPS      = CNT_W'(QUO_W);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SUM   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_FIX   = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

endpackage

// ----- src/six_channel_moving_average.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_channel_moving_average
// Windowed average of three accelerometer and three magnetometer axes.
// ----------------------------------------------------------------------------
// Each accepted word carries six signed 16-bit samples. The set is written
// into a ring of N slots (N = window_length, 0 selects 5, values above 256
// are held at 256) and each channel returns floor(sum of the N slots / N),
// with slots not yet written since the last clear counting as zero. The six
// channels pass one after another through a single restoring divider that
// resolves one quotient bit per cycle over 24 bits. The block takes a new
// word as soon as the previous one has finished, even if its result is still
// waiting in the output register. Reset and every window write clear the
// running sums and the slot pointer at once, but a write in S_SUM or S_WRITE
// loses to that state's update; the sample ring needs no clearing pass because
// a wrap flag marks when old slots become valid.
module six_channel_moving_average (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [scma_pkg::WIN_W-1:0]    cfg_wr_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_accel_x,
    input  logic signed [15:0]            s_accel_y,
    input  logic signed [15:0]            s_accel_z,
    input  logic signed [15:0]            s_mag_x,
    input  logic signed [15:0]            s_mag_y,
    input  logic signed [15:0]            s_mag_z,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_accel_x_avg,
    output logic signed [15:0]            m_accel_y_avg,
    output logic signed [15:0]            m_accel_z_avg,
    output logic signed [15:0]            m_mag_x_avg,
    output logic signed [15:0]            m_mag_y_avg,
    output logic signed [15:0]            m_mag_z_avg
);
    import scma_pkg::*;

    state_t                 state_reg, state_next;
    logic [WIN_W-1:0]       window_reg;
    logic [WIN_W-1:0]       eff_n;
    logic [SLOT_W-1:0]      slot_reg;
    logic                   wrapped_reg;
    logic [CH_W-1:0]        ch_reg;
    sum_t                   sum_reg [CHANNELS];
    sample_t                in_reg  [CHANNELS];
    sample_t                res_reg [CHANNELS];
    sample_t                out_reg [CHANNELS];
    logic                   m_valid_reg;

    logic [ROW_W-1:0]       ring_mem [MAX_WINDOW];
    logic [ROW_W-1:0]       rd_row_reg;
    logic [ROW_W-1:0]       wr_row;

    logic [QUO_W-1:0]       quo_reg, quo_next;
    logic [WIN_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   neg_reg;

    logic                   in_fire;
    logic                   out_fire;
    logic                   out_free;
    sample_t                old_sample;
    sum_t                   sum_upd;
    sum_t                   sum_cur;
    logic [SUM_W-1:0]       sum_mag;
    logic [WIN_W:0]         shifted;
    logic [WIN_W:0]         diff;
    logic                   ge;
    logic [QUO_W-1:0]       quo_signed;

    // handshakes
    assign s_ready  = (state_reg == S_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid_reg && m_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // effective window length
    always_comb begin
        if (window_reg == '0) begin
            eff_n = DEFAULT_WINDOW;
        end else if (window_reg > WINDOW_LIMIT) begin
            eff_n = WINDOW_LIMIT;
        end else begin
            eff_n = window_reg;
        end
    end

    // sample leaving the window: zero until the ring has wrapped once
    assign old_sample = wrapped_reg ? sample_t'(rd_row_reg[ch_reg * SAMPLE_W +: SAMPLE_W])
                                    : sample_t'(0);
    assign sum_cur    = sum_reg[ch_reg];
    assign sum_upd    = sum_cur
                        - {{EXT_W{old_sample[SAMPLE_W-1]}}, old_sample}
                        + {{EXT_W{in_reg[ch_reg][SAMPLE_W-1]}}, in_reg[ch_reg]};
    assign sum_mag    = sum_cur[SUM_W-1] ? (~sum_cur + SUM_W'(1)) : sum_cur;

    // one restoring divider step
    assign shifted  = {rem_reg, quo_reg[QUO_W-1]};
    assign diff     = shifted - {1'b0, eff_n};
    assign ge       = (shifted >= {1'b0, eff_n});
    assign rem_next = ge ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
    assign quo_next = {quo_reg[QUO_W-2:0], ge};

    // floor correction for negative sums
    always_comb begin
        if (!neg_reg) begin
            quo_signed = quo_reg;
        end else if (rem_reg != '0) begin
            quo_signed = ~quo_reg;
        end else begin
            quo_signed = ~quo_reg + QUO_W'(1);
        end
    end

    // row written back into the ring
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            wr_row[c * SAMPLE_W +: SAMPLE_W] = in_reg[c];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_SUM;
            S_SUM:   state_next = S_LOAD;
            S_LOAD:  state_next = S_DIV;
            S_DIV:   if (cnt_reg == DIV_STEPS - CNT_W'(1)) state_next = S_FIX;
            S_FIX:   state_next = (ch_reg == LAST_CH) ? S_WRITE : S_SUM;
            S_WRITE: state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state, slot pointer and running sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            window_reg  <= DEFAULT_WINDOW;
            slot_reg    <= '0;
            wrapped_reg <= 1'b0;
            ch_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                sum_reg[c] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                window_reg  <= cfg_wr_data;
                slot_reg    <= '0;
                wrapped_reg <= 1'b0;
                for (int c = 0; c < CHANNELS; c++) begin
                    sum_reg[c] <= '0;
                end
            end
            if (in_fire) begin
                ch_reg <= '0;
            end
            if (state_reg == S_SUM) begin
                sum_reg[ch_reg] <= sum_upd;
            end
            if (state_reg == S_LOAD) begin
                cnt_reg <= '0;
            end
            if (state_reg == S_DIV) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (state_reg == S_FIX && ch_reg != LAST_CH) begin
                ch_reg <= ch_reg + CH_W'(1);
            end
            if (state_reg == S_WRITE) begin
                if ({1'b0, slot_reg} == eff_n - WIN_W'(1)) begin
                    slot_reg    <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    slot_reg <= slot_reg + SLOT_W'(1);
                end
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (out_fire) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // sample capture, divider datapath and results
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_reg[0] <= s_accel_x;
            in_reg[1] <= s_accel_y;
            in_reg[2] <= s_accel_z;
            in_reg[3] <= s_mag_x;
            in_reg[4] <= s_mag_y;
            in_reg[5] <= s_mag_z;
        end
        if (state_reg == S_LOAD) begin
            quo_reg <= sum_mag[QUO_W-1:0];
            rem_reg <= '0;
            neg_reg <= sum_cur[SUM_W-1];
        end
        if (state_reg == S_DIV) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (state_reg == S_FIX) begin
            res_reg[ch_reg] <= sample_t'(quo_signed[SAMPLE_W-1:0]);
        end
        if (state_reg == S_DONE && out_free) begin
            for (int c = 0; c < CHANNELS; c++) begin
                out_reg[c] <= res_reg[c];
            end
        end
    end

    // sample ring, one row of six samples per slot
    always_ff @(posedge aclk) begin
        if (state_reg == S_WRITE) begin
            ring_mem[slot_reg] <= wr_row;
        end
        if (in_fire) begin
            rd_row_reg <= ring_mem[slot_reg];
        end
    end

    // result word
    assign m_accel_x_avg = out_reg[0];
    assign m_accel_y_avg = out_reg[1];
    assign m_accel_z_avg = out_reg[2];
    assign m_mag_x_avg   = out_reg[3];
    assign m_mag_y_avg   = out_reg[4];
    assign m_mag_z_avg   = out_reg[5];

    // checks
    a_slot_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, slot_reg} < eff_n))
        else $error("slot pointer outside window");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (cnt_reg < DIV_STEPS))
        else $error("divider ran past its steps");

    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && state_reg == S_IDLE) |=> (slot_reg == '0 && !wrapped_reg))
        else $error("window write did not clear the ring");

endmodule
